[design/dfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared constants, register map, types and helper functions of the
// delimited frame parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int BUFFER_DEPTH  = 64;
    localparam int MAX_DELIMITER = 4;

    // Delimiters live in a 32-bit word, so at most four bytes are usable.
    localparam int DELIM_CAP = (MAX_DELIMITER < 4) ? MAX_DELIMITER : 4;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 3;
    localparam int POS_W  = 2;
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int ADDR_W = 5;
    localparam int REG_W  = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_W-1:0] REG_START_BYTES  = 3'd0;
    localparam logic [REG_W-1:0] REG_START_LENGTH = 3'd1;
    localparam logic [REG_W-1:0] REG_END_BYTES    = 3'd2;
    localparam logic [REG_W-1:0] REG_END_LENGTH   = 3'd3;
    localparam logic [REG_W-1:0] REG_RAW_MODE     = 3'd4;

    // Reset values: start "!$%", end "%*("
    localparam logic [DATA_W-1:0] START_BYTES_RST  = 32'h0025_2421;
    localparam logic [LEN_W-1:0]  START_LENGTH_RST = 3'd3;
    localparam logic [DATA_W-1:0] END_BYTES_RST    = 32'h0028_2A25;
    localparam logic [LEN_W-1:0]  END_LENGTH_RST   = 3'd3;

    typedef struct packed {
        logic [DATA_W-1:0] start_bytes;
        logic [LEN_W-1:0]  start_length;
        logic [DATA_W-1:0] end_bytes;
        logic [LEN_W-1:0]  end_length;
        logic              raw_mode;
    } dfp_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic [CNT_W-1:0] count;
        logic             in_frame;
        logic             done;
    } dfp_state_t;

    typedef struct packed {
        logic              store_valid;
        logic [BYTE_W-1:0] store_byte;
        logic [IDX_W-1:0]  store_index;
        logic              frame_start;
        logic              frame_done;
        logic [CNT_W-1:0]  frame_length;
    } dfp_result_t;

    // Clamp a programmed length into 1..DELIM_CAP.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (res == '0) begin
            res = LEN_W'(1);
        end
        if (res > LEN_W'(DELIM_CAP)) begin
            res = LEN_W'(DELIM_CAP);
        end
        return res;
    endfunction

    // Pick byte lane pos of a delimiter word.
    function automatic logic [BYTE_W-1:0] lane(input logic [DATA_W-1:0] word,
                                               input logic [POS_W-1:0]  pos);
        return word[pos*BYTE_W +: BYTE_W];
    endfunction

endpackage

[design/dfp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_step
// Per-byte update: delimiter matching, payload indexing and frame flags,
// computed from the current state, the configuration and one byte.
// ----------------------------------------------------------------------------
module dfp_step (
    input  dfp_pkg::dfp_cfg_t             cfg,
    input  dfp_pkg::dfp_state_t           state,
    input  logic [dfp_pkg::BYTE_W-1:0]    rx_byte,
    output dfp_pkg::dfp_state_t           state_next,
    output dfp_pkg::dfp_result_t          result
);

    logic [dfp_pkg::LEN_W-1:0] slen;
    logic [dfp_pkg::LEN_W-1:0] elen;
    logic [dfp_pkg::CNT_W-1:0] cnt;
    logic [dfp_pkg::LEN_W-1:0] sp;
    logic [dfp_pkg::LEN_W-1:0] ep;
    logic [dfp_pkg::LEN_W-1:0] sp_new;
    logic [dfp_pkg::LEN_W-1:0] ep_new;

    assign slen = dfp_pkg::eff_length(cfg.start_length);
    assign elen = dfp_pkg::eff_length(cfg.end_length);

    always_comb begin
        // Wrap the write index once the buffer is full.
        cnt = (state.count >= dfp_pkg::CNT_W'(dfp_pkg::BUFFER_DEPTH)) ? '0 : state.count;
        sp = (dfp_pkg::LEN_W'(state.start_pos) >= slen) ? '0
                                                          : dfp_pkg::LEN_W'(state.start_pos);
        ep = (dfp_pkg::LEN_W'(state.end_pos) >= elen) ? '0
                                                        : dfp_pkg::LEN_W'(state.end_pos);
        sp_new = sp;
        ep_new = ep;

        state_next       = state;
        state_next.count = cnt;
        result           = '0;

        if (cfg.raw_mode) begin
            result.store_valid = 1'b1;
            result.store_byte  = rx_byte;
            result.store_index = cnt[dfp_pkg::IDX_W-1:0];
            state_next.count   = cnt + dfp_pkg::CNT_W'(1);
        end else if (!state.in_frame) begin
            if (rx_byte == dfp_pkg::lane(cfg.start_bytes, sp[dfp_pkg::POS_W-1:0])) begin
                state_next.done = 1'b0;
                sp_new          = sp + dfp_pkg::LEN_W'(1);
            end else if (rx_byte == dfp_pkg::lane(cfg.start_bytes, '0)) begin
                state_next.done = 1'b0;
                sp_new          = dfp_pkg::LEN_W'(1);
            end else begin
                sp_new = '0;
            end
            if (sp_new >= slen) begin
                sp_new              = '0;
                state_next.in_frame = 1'b1;
                state_next.count    = '0;
                state_next.end_pos  = '0;
                result.frame_start  = 1'b1;
            end
            state_next.start_pos = sp_new[dfp_pkg::POS_W-1:0];
        end else begin
            if (rx_byte == dfp_pkg::lane(cfg.end_bytes, ep[dfp_pkg::POS_W-1:0])) begin
                ep_new = ep + dfp_pkg::LEN_W'(1);
            end else if (rx_byte == dfp_pkg::lane(cfg.end_bytes, '0)) begin
                ep_new = dfp_pkg::LEN_W'(1);
            end else begin
                ep_new             = '0;
                result.store_valid = 1'b1;
                result.store_byte  = rx_byte;
                result.store_index = cnt[dfp_pkg::IDX_W-1:0];
                state_next.count   = cnt + dfp_pkg::CNT_W'(1);
            end
            if (ep_new >= elen) begin
                state_next.done     = 1'b1;
                result.frame_length = state_next.count;
                ep_new              = '0;
                state_next.count    = '0;
                state_next.in_frame = 1'b0;
            end
            state_next.end_pos = ep_new[dfp_pkg::POS_W-1:0];
        end

        result.frame_done = state_next.done;
    end

endmodule

[design/delimited_frame_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_parser_core
// Start/end delimited frame parser: hunts for a start string, then hands out
// payload bytes and their index until the end string; in raw mode, all bytes.
// ----------------------------------------------------------------------------
// Path: an accepted request sits in the input register, then moves to the
//   result register, where it is held until the consumer takes it.
// Throughput: one byte per cycle while m_ready stays high; the state update
//   is a single compare-and-increment between the input and result registers.
// Reset (aresetn low, synchronous): clear both valid flags and the parser
//   state, load the default delimiters "!$%" / "%*(" and leave raw mode off.
// ----------------------------------------------------------------------------
module delimited_frame_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfp_pkg::ADDR_W-1:0]    paddr,
    input  logic [dfp_pkg::DATA_W-1:0]    pwdata,
    output logic [dfp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    // Received bytes
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dfp_pkg::BYTE_W-1:0]    s_rx_byte,

    // Parser results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_store_valid,
    output logic [dfp_pkg::BYTE_W-1:0]    m_store_byte,
    output logic [dfp_pkg::IDX_W-1:0]     m_store_index,
    output logic                          m_frame_start,
    output logic                          m_frame_done,
    output logic [dfp_pkg::CNT_W-1:0]     m_frame_length
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    dfp_pkg::dfp_cfg_t        cfg_reg;
    logic                     cfg_write;
    logic [dfp_pkg::REG_W-1:0] reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[dfp_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_bytes  <= dfp_pkg::START_BYTES_RST;
            cfg_reg.start_length <= dfp_pkg::START_LENGTH_RST;
            cfg_reg.end_bytes    <= dfp_pkg::END_BYTES_RST;
            cfg_reg.end_length   <= dfp_pkg::END_LENGTH_RST;
            cfg_reg.raw_mode     <= 1'b0;
        end else if (cfg_write) begin
            case (reg_sel)
                dfp_pkg::REG_START_BYTES: begin
                    cfg_reg.start_bytes <= pwdata;
                end
                dfp_pkg::REG_START_LENGTH: begin
                    cfg_reg.start_length <= pwdata[dfp_pkg::LEN_W-1:0];
                end
                dfp_pkg::REG_END_BYTES: begin
                    cfg_reg.end_bytes <= pwdata;
                end
                dfp_pkg::REG_END_LENGTH: begin
                    cfg_reg.end_length <= pwdata[dfp_pkg::LEN_W-1:0];
                end
                dfp_pkg::REG_RAW_MODE: begin
                    cfg_reg.raw_mode <= pwdata[0];
                end
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            dfp_pkg::REG_START_BYTES:  prdata = cfg_reg.start_bytes;
            dfp_pkg::REG_START_LENGTH: prdata = dfp_pkg::DATA_W'(cfg_reg.start_length);
            dfp_pkg::REG_END_BYTES:    prdata = cfg_reg.end_bytes;
            dfp_pkg::REG_END_LENGTH:   prdata = dfp_pkg::DATA_W'(cfg_reg.end_length);
            dfp_pkg::REG_RAW_MODE:     prdata = dfp_pkg::DATA_W'(cfg_reg.raw_mode);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: holds one request while the result register is busy,
    // so the input side can still take a request when the consumer stalls.
    // ------------------------------------------------------------------
    logic                        in_valid_reg;
    logic [dfp_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        advance;
    logic                        s_take;

    // Advance when a byte is waiting and the result slot is free or draining.
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state and per-byte update
    // ------------------------------------------------------------------
    dfp_pkg::dfp_state_t  state_reg;
    dfp_pkg::dfp_state_t  state_next;
    dfp_pkg::dfp_result_t result_next;

    dfp_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Commit the state only when the byte moves on to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                 m_valid_reg;
    dfp_pkg::dfp_result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_store_valid  = result_reg.store_valid;
    assign m_store_byte   = result_reg.store_byte;
    assign m_store_index  = result_reg.store_index;
    assign m_frame_start  = result_reg.frame_start;
    assign m_frame_done   = result_reg.frame_done;
    assign m_frame_length = result_reg.frame_length;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // The start string completes only on a matching byte, never a payload byte.
    a_start_not_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_start |-> !m_store_valid && !m_frame_done)
        else $error("frame start flagged together with a stored byte or done flag");

    // A frame length is reported only when the frame completes.
    a_length_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_length != '0) |-> m_frame_done && !m_store_valid)
        else $error("frame length reported outside frame completion");

    // Non-stored bytes carry a zero byte and index.
    a_idle_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_store_valid |-> (m_store_byte == '0) && (m_store_index == '0))
        else $error("payload fields nonzero without store_valid");

    // The parser state only moves when a byte is handed to the result stage.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(advance) |-> $stable(state_reg))
        else $error("parser state changed without a byte advancing");
`endif

endmodule

[tb/delimited_frame_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_parser_core_tb
// Self-checking bench for the delimited frame parser. Received bytes go in
// over valid/ready and delimiter settings over the APB port. A local parser
// model predicts every result, and each field is checked as it comes out.
// Random idle cycles, a long receive stall and drained phases put the
// handshakes under load.
// ----------------------------------------------------------------------------
module delimited_frame_parser_core_tb;
    import dfp_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int MAX_IDLE   = 19;
    localparam int RUN_LIMIT  = 5_000_000;  // ns
    localparam int LONG_HOLD  = 200;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_store_valid;
    logic [BYTE_W-1:0]    m_store_byte;
    logic [IDX_W-1:0]     m_store_index;
    logic                 m_frame_start;
    logic                 m_frame_done;
    logic [CNT_W-1:0]     m_frame_length;

    delimited_frame_parser_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_store_valid  (m_store_valid),
        .m_store_byte   (m_store_byte),
        .m_store_index  (m_store_index),
        .m_frame_start  (m_frame_start),
        .m_frame_done   (m_frame_done),
        .m_frame_length (m_frame_length)
    );

    // Mirror of the delimiter registers
    logic [DATA_W-1:0] cfg_start_bytes;
    logic [LEN_W-1:0]  cfg_start_len;
    logic [DATA_W-1:0] cfg_end_bytes;
    logic [LEN_W-1:0]  cfg_end_len;
    logic              cfg_raw;

    // Mirror of the parser state
    logic [POS_W-1:0]  hunt_pos;     // matched prefix of the start string
    logic [POS_W-1:0]  tail_pos;     // matched prefix of the end string
    logic [CNT_W-1:0]  payload_cnt;
    logic              in_frame;
    logic              done_seen;

    dfp_result_t pending_results[$];
    int          fail_count = 0;
    bit          send_idle_en;
    bit          recv_idle_en;
    int          recv_hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Hard stop in case a result never shows up.
    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic int usable_len(input logic [LEN_W-1:0] len);
        int n;
        n = (len == '0) ? 1 : int'(len);
        if (n > DELIM_CAP) n = DELIM_CAP;
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] delim_byte(input logic [DATA_W-1:0] word,
                                                     input int pos);
        return word[(pos % 4) * BYTE_W +: BYTE_W];
    endfunction

    function automatic void reset_parser_model();
        cfg_start_bytes = START_BYTES_RST;
        cfg_start_len   = START_LENGTH_RST;
        cfg_end_bytes   = END_BYTES_RST;
        cfg_end_len     = END_LENGTH_RST;
        cfg_raw         = 1'b0;
        hunt_pos        = '0;
        tail_pos        = '0;
        payload_cnt     = '0;
        in_frame        = 1'b0;
        done_seen       = 1'b0;
    endfunction

    // Advance the model by one received byte and return the expected result.
    function automatic dfp_result_t parse_rx_byte(input logic [BYTE_W-1:0] rx);
        dfp_result_t res;
        int          slen;
        int          elen;
        int          pos;
        slen = usable_len(cfg_start_len);
        elen = usable_len(cfg_end_len);
        res  = '0;
        // wrap the write index once the buffer is full
        if (payload_cnt >= BUFFER_DEPTH) payload_cnt = '0;
        if (cfg_raw) begin
            res.store_valid = 1'b1;
            res.store_byte  = rx;
            res.store_index = payload_cnt[IDX_W-1:0];
            payload_cnt     = payload_cnt + 1'b1;
        end else if (!in_frame) begin
            pos = hunt_pos;
            if (pos >= slen) pos = 0;
            if (rx == delim_byte(cfg_start_bytes, pos)) begin
                done_seen = 1'b0;
                pos++;
            end else if (rx == delim_byte(cfg_start_bytes, 0)) begin
                // mismatch, but this byte opens a new start match
                done_seen = 1'b0;
                pos = 1;
            end else begin
                pos = 0;
            end
            if (pos >= slen) begin
                pos             = 0;
                in_frame        = 1'b1;
                payload_cnt     = '0;
                tail_pos        = '0;
                res.frame_start = 1'b1;
            end
            hunt_pos = pos[POS_W-1:0];
        end else begin
            pos = tail_pos;
            if (pos >= elen) pos = 0;
            if (rx == delim_byte(cfg_end_bytes, pos)) begin
                pos++;
            end else if (rx == delim_byte(cfg_end_bytes, 0)) begin
                pos = 1;
            end else begin
                // drop any partial end match, store this byte
                pos             = 0;
                res.store_valid = 1'b1;
                res.store_byte  = rx;
                res.store_index = payload_cnt[IDX_W-1:0];
                payload_cnt     = payload_cnt + 1'b1;
            end
            if (pos >= elen) begin
                done_seen        = 1'b1;
                res.frame_length = payload_cnt;
                pos              = 0;
                payload_cnt      = '0;
                in_frame         = 1'b0;
            end
            tail_pos = pos[POS_W-1:0];
        end
        res.frame_done = done_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register is written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_BYTES:  cfg_start_bytes = value;
            REG_START_LENGTH: cfg_start_len   = value[LEN_W-1:0];
            REG_END_BYTES:    cfg_end_bytes   = value;
            REG_END_LENGTH:   cfg_end_len     = value[LEN_W-1:0];
            REG_RAW_MODE:     cfg_raw         = value[0];
            default: ;
        endcase
    endtask

    task automatic set_delimiters(input logic [DATA_W-1:0] sbytes, input logic [LEN_W-1:0] slen,
                                  input logic [DATA_W-1:0] ebytes, input logic [LEN_W-1:0] elen);
        write_reg(REG_START_BYTES, sbytes);
        write_reg(REG_START_LENGTH, DATA_W'(slen));
        write_reg(REG_END_BYTES, ebytes);
        write_reg(REG_END_LENGTH, DATA_W'(elen));
    endtask

    // Offer one request and hold it until accepted. Valid stays high across
    // back-to-back requests so it is never lowered and raised in one step.
    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        int gap;
        gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(parse_rx_byte(rx));
    endtask

    // Stop sending and wait until every expected result has been checked.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Random byte, biased toward delimiter bytes to provoke partial matches.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return delim_byte(cfg_start_bytes, $urandom_range(0, 3));
        if (roll < 4) return delim_byte(cfg_end_bytes, $urandom_range(0, 3));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Random byte that cannot open an end match.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] rx;
        rx = BYTE_W'($urandom_range(0, 255));
        if (rx == delim_byte(cfg_end_bytes, 0)) rx = rx ^ 8'h01;
        return rx;
    endfunction

    // Send a delimiter string; with corrupt set, spoil about one byte in 16.
    task automatic send_delim(input logic [DATA_W-1:0] word, input int len, input bit corrupt);
        int i;
        for (i = 0; i < len; i++) begin
            if (corrupt && $urandom_range(0, 15) == 0) send_byte(pick_byte());
            else send_byte(delim_byte(word, i));
        end
    endtask

    task automatic send_frame(input int payload_len);
        int noise;
        noise = $urandom_range(0, 3);
        repeat (noise) send_byte(pick_byte());
        send_delim(cfg_start_bytes, usable_len(cfg_start_len), 1'b1);
        repeat (payload_len) send_byte(pick_byte());
        send_delim(cfg_end_bytes, usable_len(cfg_end_len), 1'b1);
    endtask

    // Mostly short frames; now and then one of 60..70 bytes, near the buffer size.
    function automatic int frame_size();
        if ($urandom_range(0, 11) == 0) return $urandom_range(60, 70);
        return $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial begin : result_checker
        dfp_result_t want;
        int          stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (recv_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (recv_hold_cycles) @(posedge aclk);
                recv_hold_cycles = 0;
            end
            stall = recv_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got byte %0d index %0d",
                         $time, m_store_byte, m_store_index);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("store_valid", 32'(want.store_valid), 32'(m_store_valid));
                check_field("store_byte", 32'(want.store_byte), 32'(m_store_byte));
                check_field("store_index", 32'(want.store_index), 32'(m_store_index));
                check_field("frame_start", 32'(want.frame_start), 32'(m_frame_start));
                check_field("frame_done", 32'(want.frame_done), 32'(m_frame_done));
                check_field("frame_length", 32'(want.frame_length), 32'(m_frame_length));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default delimiters "!$%" and "%*(": restarts, abandoned end matches,
    // an empty frame and the done flag falling on a start byte.
    task automatic test_directed_delimiters();
        logic [BYTE_W-1:0] seq [25];
        seq = '{8'h21, 8'h21, 8'h24, 8'h25,          // start mismatch restarts on '!'
                8'h00, 8'hFF, 8'h7F,                 // payload extremes
                8'h25, 8'h5A,                        // partial end dropped, 'Z' stored
                8'h25, 8'h25, 8'h2A, 8'h28,          // end mismatch reopens the match
                8'h25, 8'h21, 8'h24, 8'h58,          // noise, broken start
                8'h21, 8'h24, 8'h25,                 // start
                8'h25, 8'h2A, 8'h28,                 // end at once: empty frame
                8'h80, 8'h01};
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        foreach (seq[i]) send_byte(seq[i]);
        wait_results_drained();
    endtask

    task automatic send_long_frame(input int payload_len);
        send_delim(cfg_start_bytes, usable_len(cfg_start_len), 1'b0);
        repeat (payload_len) send_byte(plain_byte());
        send_delim(cfg_end_bytes, usable_len(cfg_end_len), 1'b0);
    endtask

    // A frame of exactly the buffer size, then one that wraps the index.
    task automatic test_index_wrap();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b0;
        send_long_frame(BUFFER_DEPTH);
        send_long_frame(BUFFER_DEPTH + 6);
        wait_results_drained();
    endtask

    // Enter raw mode in the middle of a frame, run past a wrap, then leave.
    task automatic test_raw_mode();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        send_delim(cfg_start_bytes, usable_len(cfg_start_len), 1'b0);
        repeat (5) send_byte(plain_byte());
        wait_results_drained();
        write_reg(REG_RAW_MODE, 32'd1);
        repeat (100) send_byte(pick_byte());
        wait_results_drained();
        write_reg(REG_RAW_MODE, 32'd0);
        repeat (3) send_byte(plain_byte());
        send_delim(cfg_end_bytes, usable_len(cfg_end_len), 1'b0);
        wait_results_drained();
    endtask

    // Walk through delimiter settings, extremes and out-of-range lengths
    // included; the last entry puts the reset values back.
    task automatic test_config_sweep();
        logic [DATA_W-1:0] sb [7];
        logic [DATA_W-1:0] eb [7];
        logic [LEN_W-1:0]  sl [7];
        logic [LEN_W-1:0]  el [7];
        int                i;
        sb = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hA5A5_A5A5, 32'h0,
               START_BYTES_RST};
        eb = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 32'hA5A5_A5A5, 32'h0,
               END_BYTES_RST};
        sl = '{3'd4, 3'd1, 3'd0, 3'd5, 3'd2, 3'd4, START_LENGTH_RST};
        el = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd2, 3'd3, END_LENGTH_RST};
        for (i = 2; i < 6; i++) begin
            if (i == 4) continue;
            sb[i] = $urandom();
            eb[i] = $urandom();
        end
        for (i = 0; i < 7; i++) begin
            wait_results_drained();
            set_delimiters(sb[i], sl[i], eb[i], el[i]);
            send_idle_en = (i % 2) == 0;
            recv_idle_en = (i % 3) != 0;
            repeat (6) send_frame(frame_size());
        end
        wait_results_drained();
    endtask

    // Stall the receiver for a long stretch while bytes keep coming, so the
    // block fills up and stops accepting.
    task automatic test_backpressure();
        send_idle_en     = 1'b0;
        recv_idle_en     = 1'b0;
        recv_hold_cycles = LONG_HOLD;
        repeat (6) send_frame($urandom_range(0, 12));
        wait_results_drained();
    endtask

    // Random frames with random idling; reprogram the delimiters now and then.
    task automatic test_random_frames();
        int n;
        for (n = 0; n < 16; n++) begin
            if (n % 8 == 7) begin
                wait_results_drained();
                set_delimiters($urandom(), LEN_W'($urandom_range(0, 7)),
                               $urandom(), LEN_W'($urandom_range(0, 7)));
            end
            send_idle_en = $urandom_range(0, 3) != 0;
            recv_idle_en = $urandom_range(0, 3) != 0;
            send_frame(frame_size());
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        send_idle_en     = 1'b0;
        recv_idle_en     = 1'b0;
        recv_hold_cycles = 0;
        reset_parser_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_delimiters();
        test_index_wrap();
        test_raw_mode();
        test_config_sweep();
        test_backpressure();
        test_random_frames();

        // let any stray result show up before the verdict
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
